// ===== hdl/lzf_pkg.sv =====
// Shared constants and codes for the LZF block decompressor.
// No dependencies; compile first.
package lzf_pkg;

  localparam int WINDOW_BYTES     = 8192;
  localparam int BYTES_PER_RESULT = 8;
  localparam int RING_AW          = $clog2(WINDOW_BYTES);
  localparam int CFG_IDX_W        = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH   = 8'd1;

  localparam logic [2:0] PH_CTRL = 3'd0;
  localparam logic [2:0] PH_LIT  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_OFS  = 3'd3;
  localparam logic [2:0] PH_DROP = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LIT_TRUNC = 3'd1;
  localparam logic [2:0] ERR_LIT_OVER  = 3'd2;
  localparam logic [2:0] ERR_LEN_TRUNC = 3'd3;
  localparam logic [2:0] ERR_REF_TRUNC = 3'd4;
  localparam logic [2:0] ERR_REF_BAD   = 3'd5;
  localparam logic [2:0] ERR_REF_OVER  = 3'd6;
  localparam logic [2:0] ERR_SIZE      = 3'd7;

endpackage

// ===== hdl/lzf_in_if.sv =====
// Input channel of the LZF decompressor: one compressed byte per transfer.
// Depends on nothing.
interface lzf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] compressed_byte;
  modport source (output valid, output compressed_byte, input ready);
  modport sink   (input valid, input compressed_byte, output ready);
endinterface

// ===== hdl/lzf_out_if.sv =====
// Result channel of the LZF decompressor: up to eight decoded bytes per transfer.
// Depends on nothing.
interface lzf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_bytes;
  logic [3:0]  byte_count;
  logic [2:0]  status_code;
  logic        run_last;
  logic        block_done;
  modport source (output valid, output decoded_bytes, output byte_count, output status_code,
                  output run_last, output block_done, input ready);
  modport sink   (input valid, input decoded_bytes, input byte_count, input status_code,
                  input run_last, input block_done, output ready);
endinterface

// ===== hdl/lzf_cfg_if.sv =====
// Configuration write channel of the LZF decompressor.
// Depends on nothing.
interface lzf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hdl/lzf_block_decompressor_unit.sv =====
// Top level of the LZF block decompressor with its 8 KiB history memory.
// Depends on lzf_pkg and the interfaces lzf_in_if, lzf_out_if, lzf_cfg_if.
//
// Channel  Dir  Payload                                              Transfer
// in_ch    in   compressed_byte                                      valid & ready
// out_ch   out  decoded_bytes, byte_count, status_code, run_last,    valid & ready
//               block_done
// cfg_ch   in   reg_index, wdata                                     valid & ready
//
// A control, length, offset or literal byte is taken when the output register is free.
// A back reference runs through the one-read one-write history memory at one byte
// per cycle while the output is not stalled, pausing to hand on each eight-byte result.
// Reset is synchronous; the history memory is not cleared.
// A stalled output holds the copy and the input channel.
module lzf_block_decompressor_unit
  import lzf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  lzf_in_if.sink    in_ch,
  lzf_out_if.source out_ch,
  lzf_cfg_if.sink   cfg_ch
);

  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_E7   = 2'd2;

  logic [7:0] ring [WINDOW_BYTES];
  logic [7:0] mem_q_r;
  logic                mem_re, mem_we;
  logic [RING_AW-1:0]  mem_ra, mem_wa;
  logic [7:0]          mem_wd;

  logic [1:0]  st_r, st_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [5:0]  lit_rem_r, lit_rem_nxt;
  logic [8:0]  mlen_r, mlen_nxt;
  logic [4:0]  ofs_hi_r, ofs_hi_nxt;
  logic [31:0] dec_r, dec_nxt, cons_r, cons_nxt, clen_r, clen_nxt, elen_r, elen_nxt;
  logic [8:0]  len_r, len_nxt, rd_idx_r, rd_idx_nxt, wr_idx_r, wr_idx_nxt;
  logic [RING_AW-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic        rv_r, rv_nxt, fwd_r, fwd_nxt, endp_r, endp_nxt, e7_r, e7_nxt;
  logic [7:0]  fwd_d_r, fwd_d_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  wcnt_r, wcnt_nxt;

  logic        out_v_r;
  logic [63:0] out_d_r;
  logic [3:0]  out_c_r;
  logic [2:0]  out_e_r;
  logic        out_l_r, out_b_r;

  logic        push, push_last, push_done;
  logic [63:0] push_d;
  logic [3:0]  push_c;
  logic [2:0]  push_e;

  logic        can_push, in_acc, cfg_acc, clear, lit_out, go_copy, issue, mism, fin;
  logic [7:0]  b, arr_byte;
  logic [31:0] rem;
  logic        at_end;
  logic [5:0]  lit_len;
  logic [12:0] ref_ofs;
  logic [8:0]  cp_len;
  logic [2:0]  err;

  assign can_push     = !out_v_r || out_ch.ready;
  assign in_ch.ready  = (st_r == ST_IN) && can_push && !cfg_ch.valid;
  assign cfg_ch.ready = (st_r == ST_IN);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  assign b        = in_ch.compressed_byte;
  assign rem      = (clen_r - 32'd1) - cons_r;
  assign at_end   = (rem == 32'd0);
  assign lit_len  = {1'b0, b[4:0]} + 6'd1;
  assign ref_ofs  = {ofs_hi_r, b};
  assign cp_len   = mlen_r + 9'd2;
  assign arr_byte = fwd_r ? fwd_d_r : mem_q_r;

  always_comb begin
    st_nxt = st_r;       phase_nxt = phase_r;   lit_rem_nxt = lit_rem_r;
    mlen_nxt = mlen_r;   ofs_hi_nxt = ofs_hi_r; dec_nxt = dec_r;
    cons_nxt = cons_r;   clen_nxt = clen_r;     elen_nxt = elen_r;
    len_nxt = len_r;     rd_idx_nxt = rd_idx_r; wr_idx_nxt = wr_idx_r;
    src_nxt = src_r;     dst_nxt = dst_r;       rv_nxt = 1'b0;
    fwd_nxt = 1'b0;      fwd_d_nxt = arr_byte;  endp_nxt = endp_r;
    e7_nxt = e7_r;       word_nxt = word_r;     wcnt_nxt = wcnt_r;
    push = 1'b0; push_d = 64'd0; push_c = 4'd0; push_e = ERR_NONE;
    push_last = 1'b0; push_done = 1'b0;
    mem_re = 1'b0; mem_ra = '0; mem_we = 1'b0; mem_wa = '0; mem_wd = b;
    clear = 1'b0; lit_out = 1'b0; go_copy = 1'b0; issue = 1'b0; mism = 1'b0;
    fin = 1'b0; err = ERR_NONE;

    unique case (st_r)
      ST_IN: begin
        if (cfg_acc) begin
          if (cfg_ch.reg_index == REG_COMPRESSED_LENGTH) begin
            clen_nxt = cfg_ch.wdata;
            clear = 1'b1;
          end else if (cfg_ch.reg_index == REG_EXPECTED_LENGTH) begin
            elen_nxt = cfg_ch.wdata;
            clear = 1'b1;
          end
        end else if (in_acc) begin
          cons_nxt = cons_r + 32'd1;
          case (phase_r)
            PH_CTRL: begin
              if (b[7:5] == 3'd0) begin
                if (rem < {26'd0, lit_len}) begin
                  err = ERR_LIT_TRUNC;
                end else if (({1'b0, dec_r} + {27'd0, lit_len}) > {1'b0, elen_r}) begin
                  err = ERR_LIT_OVER;
                end else begin
                  lit_rem_nxt = lit_len;
                  phase_nxt = PH_LIT;
                end
              end else begin
                ofs_hi_nxt = b[4:0];
                mlen_nxt = {6'd0, b[7:5]};
                if (b[7:5] == 3'd7) begin
                  if (at_end) err = ERR_LEN_TRUNC;
                  else phase_nxt = PH_LEN;
                end else begin
                  if (at_end) err = ERR_REF_TRUNC;
                  else phase_nxt = PH_OFS;
                end
              end
            end
            PH_LIT: begin
              mem_we = 1'b1;
              mem_wa = dec_r[RING_AW-1:0];
              dec_nxt = dec_r + 32'd1;
              lit_out = 1'b1;
              lit_rem_nxt = lit_rem_r - 6'd1;
              if (lit_rem_r == 6'd1) phase_nxt = PH_CTRL;
            end
            PH_LEN: begin
              mlen_nxt = 9'd7 + {1'b0, b};
              if (at_end) err = ERR_REF_TRUNC;
              else phase_nxt = PH_OFS;
            end
            PH_OFS: begin
              if ({19'd0, ref_ofs} >= dec_r) begin
                err = ERR_REF_BAD;
              end else if (({1'b0, dec_r} + {24'd0, cp_len}) > {1'b0, elen_r}) begin
                err = ERR_REF_OVER;
              end else begin
                go_copy = 1'b1;
                len_nxt = cp_len;
                src_nxt = dec_r[RING_AW-1:0] - ref_ofs - 13'd1;
                dst_nxt = dec_r[RING_AW-1:0];
                rd_idx_nxt = 9'd0;
                wr_idx_nxt = 9'd0;
                word_nxt = 64'd0;
                wcnt_nxt = 4'd0;
                endp_nxt = at_end;
                e7_nxt = at_end && ((dec_r + {23'd0, cp_len}) != elen_r);
                dec_nxt = dec_r + {23'd0, cp_len};
                phase_nxt = PH_CTRL;
                st_nxt = ST_COPY;
              end
            end
            default: ;
          endcase

          if (err != ERR_NONE) begin
            push = 1'b1; push_e = err; push_last = 1'b1; push_done = 1'b1;
            if (at_end) clear = 1'b1;
            else phase_nxt = PH_DROP;
          end else if (lit_out) begin
            mism = at_end && ((phase_nxt != PH_CTRL) || (dec_nxt != elen_r));
            push = 1'b1; push_d = {56'd0, b}; push_c = 4'd1;
            push_last = !mism; push_done = at_end && !mism;
            if (mism) st_nxt = ST_E7;
            else if (at_end) clear = 1'b1;
          end else if (!go_copy && at_end) begin
            if ((phase_r != PH_DROP) &&
                ((phase_nxt != PH_CTRL) || (dec_nxt != elen_r))) begin
              push = 1'b1; push_e = ERR_SIZE; push_last = 1'b1; push_done = 1'b1;
            end
            clear = 1'b1;
          end
        end
      end
      ST_COPY: begin
        issue = (rd_idx_r < len_r) && ((wcnt_r + {3'd0, rv_r}) < 4'd8);
        if (issue) begin
          mem_re = 1'b1;
          mem_ra = src_r + {4'd0, rd_idx_r};
          rd_idx_nxt = rd_idx_r + 9'd1;
        end
        rv_nxt = issue;
        if (rv_r) begin
          mem_we = 1'b1;
          mem_wa = dst_r + {4'd0, wr_idx_r};
          mem_wd = arr_byte;
          word_nxt[wcnt_r[2:0]*8 +: 8] = arr_byte;
          wcnt_nxt = wcnt_r + 4'd1;
          wr_idx_nxt = wr_idx_r + 9'd1;
        end
        fwd_nxt = issue && rv_r && (mem_ra == mem_wa);
        fin = (wr_idx_r == len_r);
        if (((wcnt_r == 4'd8) || (fin && (wcnt_r != 4'd0))) && can_push) begin
          push = 1'b1; push_d = word_r; push_c = wcnt_r;
          push_last = fin && !e7_r; push_done = fin && endp_r && !e7_r;
          word_nxt = 64'd0;
          wcnt_nxt = 4'd0;
          if (fin) begin
            st_nxt = e7_r ? ST_E7 : ST_IN;
            if (endp_r && !e7_r) clear = 1'b1;
          end
        end
      end
      ST_E7: begin
        if (can_push) begin
          push = 1'b1; push_e = ERR_SIZE; push_last = 1'b1; push_done = 1'b1;
          st_nxt = ST_IN;
          clear = 1'b1;
        end
      end
      default: st_nxt = ST_IN;
    endcase

    if (clear) begin
      dec_nxt = 32'd0; cons_nxt = 32'd0; phase_nxt = PH_CTRL;
      lit_rem_nxt = 6'd0; mlen_nxt = 9'd0; ofs_hi_nxt = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= ring[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IN;      phase_r <= PH_CTRL; lit_rem_r <= 6'd0;
      mlen_r <= 9'd0;     ofs_hi_r <= 5'd0;   dec_r <= 32'd0;
      cons_r <= 32'd0;    clen_r <= 32'd1;    elen_r <= 32'd0;
      rv_r <= 1'b0;       fwd_r <= 1'b0;      out_v_r <= 1'b0;
      wcnt_r <= 4'd0;     word_r <= 64'd0;
    end else begin
      st_r <= st_nxt;     phase_r <= phase_nxt; lit_rem_r <= lit_rem_nxt;
      mlen_r <= mlen_nxt; ofs_hi_r <= ofs_hi_nxt; dec_r <= dec_nxt;
      cons_r <= cons_nxt; clen_r <= clen_nxt;   elen_r <= elen_nxt;
      rv_r <= rv_nxt;     fwd_r <= fwd_nxt;
      wcnt_r <= wcnt_nxt; word_r <= word_nxt;
      if (push) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;  rd_idx_r <= rd_idx_nxt; wr_idx_r <= wr_idx_nxt;
    src_r <= src_nxt;  dst_r <= dst_nxt;       fwd_d_r <= fwd_d_nxt;
    endp_r <= endp_nxt; e7_r <= e7_nxt;
    if (push) begin
      out_d_r <= push_d; out_c_r <= push_c; out_e_r <= push_e;
      out_l_r <= push_last; out_b_r <= push_done;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.decoded_bytes = out_d_r;
  assign out_ch.byte_count    = out_c_r;
  assign out_ch.status_code   = out_e_r;
  assign out_ch.run_last      = out_l_r;
  assign out_ch.block_done    = out_b_r;

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_e_r != ERR_NONE)) |-> ((out_c_r == 4'd0) && out_b_r && out_l_r))
    else $error("error result carries data or misses its end flags");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_e_r == ERR_NONE)) |-> ((out_c_r != 4'd0) && (out_c_r <= 4'd8)))
    else $error("data result has a bad byte count");

  a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COPY) |-> ((wcnt_r + {3'd0, rv_r}) <= 4'd8))
    else $error("copy packer overflow");

  a_copy_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COPY) |-> !in_ch.ready)
    else $error("input taken during a copy");

endmodule
